[hdl/vpd_pkg.sv]
`timescale 1ns / 1ps
package vpd_pkg;

  // Item field widths
  localparam int BYTE_ADDR_W   = 11;
  localparam int BYTE_W        = 8;
  localparam int RESUME_OFF_W  = 16;
  localparam int PKT_OFF_W     = 11;

  // Walk offsets: wide enough for a resume offset and for a step past image_size
  localparam int OFF_W         = 16;

  // Configuration registers
  localparam int IMAGE_SIZE_W  = 12;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic REG_IMAGE_SIZE    = 1'b0;
  localparam logic REG_TERMINATOR_ID = 1'b1;

  localparam logic [IMAGE_SIZE_W-1:0] IMAGE_SIZE_RESET = 12'd2048;
  localparam logic [BYTE_W-1:0]       TERMINATOR_RESET = 8'd255;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage

[hdl/vpd_if.sv]
`timescale 1ns / 1ps
interface vpd_req_if import vpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [BYTE_ADDR_W-1:0]  byte_address;
  logic [BYTE_W-1:0]       byte_value;
  logic [BYTE_W-1:0]       wanted_id;
  logic                    resume;
  logic [RESUME_OFF_W-1:0] resume_offset;

  modport source (
    output valid, operation, byte_address, byte_value, wanted_id, resume, resume_offset,
    input  ready
  );
  modport sink (
    input  valid, operation, byte_address, byte_value, wanted_id, resume, resume_offset,
    output ready
  );
endinterface

interface vpd_rsp_if import vpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [PKT_OFF_W-1:0] packet_offset;

  modport source (
    output valid, found, packet_offset,
    input  ready
  );
  modport sink (
    input  valid, found, packet_offset,
    output ready
  );
endinterface

[hdl/vpd_packet_search.sv]
`timescale 1ns / 1ps
// Packet search over a byte image of a product-data SROM.
//
// req: one word per item. A load word (operation 0) writes byte_value at
//   byte_address. A search word (operation 1) walks the packet list from
//   just after the image header, or from the packet after resume_offset,
//   and looks for wanted_id.
// rsp: one word per search (found, packet_offset); loads give none.
// APB: register 0 at byte address 0 is image_size, register 1 at byte
//   address 4 is terminator_id. Write them only while no item is in flight.
//
// One item at a time. The image sits in a single-port RAM with registered
// read data; each packet passed over costs two reads (id, then length),
// each through an address state and a data state. With a MEM_DEPTH that
// is not a power of two, an address past the depth is brought down by
// one MEM_DEPTH per pass through the address state.
// A finished result sits in an output register; the next item is taken
// while it waits. If the receiver still holds a result when the next
// search finishes, the block waits until that word is taken.
// Reset clears control state and restores both registers; the image RAM
// is not cleared and reads as undefined until written.
module vpd_packet_search import vpd_pkg::*; #(
  parameter int MEM_DEPTH           = 2048,
  parameter int IMAGE_HEADER_BYTES  = 32,
  parameter int PACKET_HEADER_BYTES = 2,
  parameter int ID_FIELD_OFFSET     = 0,
  parameter int LENGTH_FIELD_OFFSET = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  vpd_req_if.sink               req,
  vpd_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int  AW       = $clog2(MEM_DEPTH);
  localparam bit  IS_POW2  = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
  localparam logic [OFF_W:0] DEPTH_X = (OFF_W + 1)'(MEM_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_ADDR, S_DATA, S_DONE} state_t;
  typedef enum logic [1:0] {K_WRITE, K_ID, K_LEN} kind_t;

  state_t                  state;
  kind_t                   kind;
  logic [OFF_W-1:0]        off;
  logic [OFF_W-1:0]        addr;
  logic [BYTE_W-1:0]       wbyte;
  logic [BYTE_W-1:0]       wanted;
  logic                    hit;
  logic [IMAGE_SIZE_W-1:0] image_size;
  logic [BYTE_W-1:0]       terminator_id;
  logic                    out_valid;
  logic                    out_found;
  logic [PKT_OFF_W-1:0]    out_offset;

  logic                    req_fire;
  logic                    rsp_fire;
  logic                    addr_high;
  logic                    ram_we;
  logic [BYTE_W-1:0]       ram_rdata;
  logic [OFF_W-1:0]        step_next;
  logic                    step_out;
  logic [OFF_W-1:0]        start_off;
  logic                    resume_out;

  // Fold an address into the RAM at once when the depth is a power of two
  function automatic logic [OFF_W-1:0] fold(input logic [OFF_W-1:0] a);
    if (IS_POW2) begin
      return a & OFF_W'(MEM_DEPTH - 1);
    end
    return a;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = out_valid && rsp.ready;

  assign rsp.valid         = out_valid;
  assign rsp.found         = out_found;
  assign rsp.packet_offset = out_offset;

  // Address reduction and RAM access
  assign addr_high = {1'b0, addr} >= DEPTH_X;
  assign ram_we    = (state == S_ADDR) && !addr_high && (kind == K_WRITE);

  vpd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr[AW-1:0]),
    .wdata (wbyte),
    .rdata (ram_rdata)
  );

  // Step to the next packet and check it against image_size
  assign step_next  = off + OFF_W'(ram_rdata) + OFF_W'(PACKET_HEADER_BYTES);
  assign step_out   = step_next >= OFF_W'(image_size);
  assign start_off  = OFF_W'(IMAGE_HEADER_BYTES);
  assign resume_out = req.resume_offset >= OFF_W'(image_size);

  // Search sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= K_WRITE;
      out_valid <= 1'b0;
    end else begin
      if (rsp_fire && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            wanted <= req.wanted_id;
            wbyte  <= req.byte_value;
            if (req.operation == OP_LOAD) begin
              kind  <= K_WRITE;
              addr  <= fold(OFF_W'(req.byte_address));
              state <= S_ADDR;
            end else if (req.resume) begin
              off <= req.resume_offset;
              hit <= 1'b0;
              if (resume_out) begin
                state <= S_DONE;
              end else begin
                kind  <= K_LEN;
                addr  <= fold(req.resume_offset + OFF_W'(LENGTH_FIELD_OFFSET));
                state <= S_ADDR;
              end
            end else begin
              off   <= start_off;
              kind  <= K_ID;
              addr  <= fold(start_off + OFF_W'(ID_FIELD_OFFSET));
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          if (addr_high) begin
            addr <= addr - OFF_W'(MEM_DEPTH);
          end else if (kind == K_WRITE) begin
            state <= S_IDLE;
          end else begin
            state <= S_DATA;
          end
        end
        S_DATA: begin
          if (kind == K_ID) begin
            if (ram_rdata == terminator_id) begin
              hit   <= 1'b0;
              state <= S_DONE;
            end else if (ram_rdata == wanted) begin
              hit   <= 1'b1;
              state <= S_DONE;
            end else begin
              kind  <= K_LEN;
              addr  <= fold(off + OFF_W'(LENGTH_FIELD_OFFSET));
              state <= S_ADDR;
            end
          end else begin
            if (step_out) begin
              hit   <= 1'b0;
              state <= S_DONE;
            end else begin
              off   <= step_next;
              kind  <= K_ID;
              addr  <= fold(step_next + OFF_W'(ID_FIELD_OFFSET));
              state <= S_ADDR;
            end
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_found  <= hit;
            out_offset <= hit ? off[PKT_OFF_W-1:0] : '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size    <= IMAGE_SIZE_RESET;
      terminator_id <= TERMINATOR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_IMAGE_SIZE:    image_size    <= pwdata[IMAGE_SIZE_W-1:0];
        REG_TERMINATOR_ID: terminator_id <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;

  // Read back
  always_comb begin
    case (paddr[2])
      REG_IMAGE_SIZE:    prdata = APB_DATA_W'(image_size);
      REG_TERMINATOR_ID: prdata = APB_DATA_W'(terminator_id);
      default:           prdata = '0;
    endcase
  end

endmodule

[hdl/vpd_ram.sv]
`timescale 1ns / 1ps
module vpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sim/tb_vpd_packet_search.sv]
`timescale 1ns / 1ps
module tb_vpd_packet_search import vpd_pkg::*;;

  localparam int MEM_DEPTH           = 2048;
  localparam int IMAGE_HEADER_BYTES  = 32;
  localparam int PACKET_HEADER_BYTES = 2;
  localparam int ID_FIELD_OFFSET     = 0;
  localparam int LENGTH_FIELD_OFFSET = 1;

  // lets a trailing load finish; a load gives no result word
  localparam int LOAD_SETTLE_CYCLES  = 16;

  typedef struct {
    logic                    operation;
    logic [BYTE_ADDR_W-1:0]  byte_address;
    logic [BYTE_W-1:0]       byte_value;
    logic [BYTE_W-1:0]       wanted_id;
    logic                    resume;
    logic [RESUME_OFF_W-1:0] resume_offset;
  } req_word_t;

  typedef struct packed {
    logic                 readable;
    logic                 found;
    logic [PKT_OFF_W-1:0] offset;
  } search_outcome_t;

  // Shadow of the image and registers; predicts each search and checks results
  class search_scoreboard;
    logic [BYTE_W-1:0] image [MEM_DEPTH];
    bit                filled [MEM_DEPTH];
    int unsigned       size_reg;
    logic [BYTE_W-1:0] term_reg;
    search_outcome_t   pending_answers [$];
    int                mismatches;

    function new();
      foreach (image[i]) begin
        image[i]  = '0;
        filled[i] = 1'b0;
      end
      size_reg   = 32'(IMAGE_SIZE_RESET);
      term_reg   = TERMINATOR_RESET;
      mismatches = 0;
    endfunction

    function void set_register(input logic idx, input logic [APB_DATA_W-1:0] value);
      if (idx == REG_IMAGE_SIZE) begin
        size_reg = 32'(value[IMAGE_SIZE_W-1:0]);
      end else if (idx == REG_TERMINATOR_ID) begin
        term_reg = value[BYTE_W-1:0];
      end
    endfunction

    // Walk the packet list; readable drops if any byte touched was never loaded
    function search_outcome_t walk_packets(input logic [BYTE_W-1:0] wanted,
                                           input logic from_resume,
                                           input logic [RESUME_OFF_W-1:0] start_at);
      search_outcome_t r;
      int unsigned     off;
      int unsigned     len_at;
      logic [BYTE_W-1:0] id;
      r.readable = 1'b1;
      r.found    = 1'b0;
      r.offset   = '0;
      if (from_resume) begin
        if (start_at >= size_reg) return r;
        len_at = (start_at + LENGTH_FIELD_OFFSET) % MEM_DEPTH;
        r.readable &= filled[len_at];
        off = start_at + image[len_at] + PACKET_HEADER_BYTES;
        if (off >= size_reg) return r;
      end else begin
        // the first packet is read without a bounds check
        off = IMAGE_HEADER_BYTES;
      end
      while (1'b1) begin
        len_at = (off + LENGTH_FIELD_OFFSET) % MEM_DEPTH;
        r.readable &= filled[(off + ID_FIELD_OFFSET) % MEM_DEPTH] & filled[len_at];
        id = image[(off + ID_FIELD_OFFSET) % MEM_DEPTH];
        // terminator wins even when it is the wanted id
        if (id == term_reg) return r;
        if (id == wanted) begin
          r.found  = 1'b1;
          r.offset = PKT_OFF_W'(off);
          return r;
        end
        off = off + image[len_at] + PACKET_HEADER_BYTES;
        if (off >= size_reg) return r;
      end
      return r;
    endfunction

    function void note_word(input req_word_t w);
      if (w.operation == OP_LOAD) begin
        image[w.byte_address % MEM_DEPTH]  = w.byte_value;
        filled[w.byte_address % MEM_DEPTH] = 1'b1;
      end else begin
        pending_answers.push_back(walk_packets(w.wanted_id, w.resume, w.resume_offset));
      end
    endfunction

    function void flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d at %0t: %s", mismatches, $time, msg);
    endfunction

    function void check_answer(input logic found, input logic [PKT_OFF_W-1:0] offset);
      search_outcome_t want;
      if (pending_answers.size() == 0) begin
        flag_error($sformatf("result word with no search pending: found %b offset %0d",
                             found, offset));
        return;
      end
      want = pending_answers.pop_front();
      if (found !== want.found || offset !== want.offset) begin
        flag_error($sformatf("expected found %b offset %0d, got found %b offset %0d",
                             want.found, want.offset, found, offset));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  vpd_req_if req_ch ();
  vpd_rsp_if rsp_ch ();

  search_scoreboard board;
  int send_idle_pct  = 23;
  int recv_stall_pct = 69;
  int words_sent     = 0;

  vpd_packet_search #(
    .MEM_DEPTH          (MEM_DEPTH),
    .IMAGE_HEADER_BYTES (IMAGE_HEADER_BYTES),
    .PACKET_HEADER_BYTES(PACKET_HEADER_BYTES),
    .ID_FIELD_OFFSET    (ID_FIELD_OFFSET),
    .LENGTH_FIELD_OFFSET(LENGTH_FIELD_OFFSET)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      board.check_answer(rsp_ch.found, rsp_ch.packet_offset);
    end
  end

  // Offer one word, idling at random first, and hold it until taken
  task automatic send_word(input req_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= w.operation;
    req_ch.byte_address  <= w.byte_address;
    req_ch.byte_value    <= w.byte_value;
    req_ch.wanted_id     <= w.wanted_id;
    req_ch.resume        <= w.resume;
    req_ch.resume_offset <= w.resume_offset;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_word(w);
    words_sent++;
  endtask

  task automatic load_byte(input int unsigned addr, input logic [BYTE_W-1:0] value);
    req_word_t w;
    w.operation     = OP_LOAD;
    w.byte_address  = BYTE_ADDR_W'(addr);
    w.byte_value    = value;
    w.wanted_id     = BYTE_W'($urandom);
    w.resume        = 1'($urandom_range(0, 1));
    w.resume_offset = RESUME_OFF_W'($urandom);
    send_word(w);
  endtask

  // Issue a search only when every byte it walks over has been loaded
  task automatic try_search(input logic [BYTE_W-1:0] wanted, input logic resume,
                            input logic [RESUME_OFF_W-1:0] roff);
    req_word_t       w;
    search_outcome_t probe;
    w.operation     = OP_SEARCH;
    w.byte_address  = BYTE_ADDR_W'($urandom);
    w.byte_value    = BYTE_W'($urandom);
    w.wanted_id     = wanted;
    w.resume        = resume;
    w.resume_offset = roff;
    probe = board.walk_packets(wanted, resume, roff);
    if (probe.readable) send_word(w);
  endtask

  // Drop valid, wait out all results, then let a trailing load finish
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Lay down a packet list with random content, then search it in several ways
  task automatic build_and_search();
    int unsigned       base;
    int unsigned       off;
    int unsigned       len;
    int unsigned       n;
    int unsigned       j;
    int unsigned       kind;
    int unsigned       pkt_off [$];
    logic [BYTE_W-1:0] pkt_id [$];
    logic [BYTE_W-1:0] id;
    bit                closed;
    base   = ($urandom_range(0, 9) < 7) ? IMAGE_HEADER_BYTES
                                        : $urandom_range(0, MEM_DEPTH - 64);
    n      = $urandom_range(1, 12);
    closed = ($urandom_range(0, 4) != 0);
    off    = base;
    while (pkt_off.size() < n && off + PACKET_HEADER_BYTES < MEM_DEPTH) begin
      id = BYTE_W'($urandom);
      if (id == board.term_reg) id ^= 8'h01;
      if (closed && pkt_off.size() == n - 1) id = board.term_reg;
      len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : $urandom_range(0, 255);
      load_byte(off + ID_FIELD_OFFSET, id);
      load_byte(off + LENGTH_FIELD_OFFSET, BYTE_W'(len));
      if (len > 0 && $urandom_range(0, 5) == 0) begin
        load_byte(off + PACKET_HEADER_BYTES + $urandom_range(0, len - 1),
                  BYTE_W'($urandom));
      end
      pkt_off.push_back(off);
      pkt_id.push_back(id);
      off += len + PACKET_HEADER_BYTES;
    end
    // now and then scribble over random bytes
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        load_byte($urandom_range(0, MEM_DEPTH - 1), BYTE_W'($urandom));
      end
    end
    repeat ($urandom_range(2, 8)) begin
      j    = $urandom_range(0, pkt_off.size() - 1);
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          if (j > 0 && $urandom_range(0, 1) == 1) begin
            try_search(pkt_id[j], 1'b1,
                       RESUME_OFF_W'(pkt_off[$urandom_range(0, j - 1)]));
          end else begin
            try_search(pkt_id[j], 1'b0, RESUME_OFF_W'($urandom));
          end
        end
        4, 5: try_search(BYTE_W'($urandom), 1'b0, RESUME_OFF_W'($urandom));
        6:    try_search(board.term_reg, 1'($urandom_range(0, 1)),
                         RESUME_OFF_W'(pkt_off[j]));
        7:    try_search(BYTE_W'($urandom), 1'b1, RESUME_OFF_W'($urandom));
        8:    try_search(BYTE_W'($urandom), 1'b1, RESUME_OFF_W'(pkt_off[j]));
        default: load_byte($urandom_range(0, MEM_DEPTH - 1), BYTE_W'($urandom));
      endcase
    end
  endtask

  task automatic run_scenes(input int count);
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) build_and_search();
  endtask

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    board = new();
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_LOAD;
    req_ch.byte_address  <= '0;
    req_ch.byte_value    <= '0;
    req_ch.wanted_id     <= '0;
    req_ch.resume        <= 1'b0;
    req_ch.resume_offset <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // packet list after the header: 32 -> 37 -> 39 -> 296 -> terminator at 298
    load_byte(32, 8'h01);
    load_byte(33, 8'd3);
    load_byte(37, 8'h80);
    load_byte(38, 8'd0);
    load_byte(39, 8'h7F);
    load_byte(40, 8'd255);
    load_byte(296, 8'hFE);
    load_byte(297, 8'd0);
    load_byte(298, TERMINATOR_RESET);
    load_byte(299, 8'd0);
    try_search(8'h01, 1'b0, 16'd0);
    try_search(8'h7F, 1'b0, 16'hFFFF);
    try_search(8'hFE, 1'b1, 16'd39);
    // terminator as the wanted id never matches
    try_search(TERMINATOR_RESET, 1'b0, 16'd0);
    try_search(8'h00, 1'b0, 16'd0);
    // resume offsets already out of range
    try_search(8'h01, 1'b1, 16'hFFFF);
    try_search(8'h01, 1'b1, 16'd2048);
    wait_idle();

    // empty image: the start packet is still read unchecked
    write_register(REG_IMAGE_SIZE, 0);
    try_search(8'h01, 1'b0, 16'd0);
    try_search(8'h80, 1'b0, 16'd0);
    wait_idle();

    // next-packet offset lands exactly on image_size
    write_register(REG_IMAGE_SIZE, 296);
    try_search(8'hFE, 1'b0, 16'd0);
    try_search(8'hFE, 1'b1, 16'd39);
    wait_idle();

    // packet at the top of memory has its length byte wrapped to address 0
    write_register(REG_IMAGE_SIZE, APB_DATA_W'(IMAGE_SIZE_RESET));
    write_register(REG_TERMINATOR_ID, APB_DATA_W'(TERMINATOR_RESET));
    load_byte(2047, 8'h42);
    load_byte(0, 8'd5);
    load_byte(2041, 8'd5);
    try_search(8'h42, 1'b1, 16'd2040);
    try_search(8'h42, 1'b1, 16'd2047);

    // random lists, with one full drain in the middle
    run_scenes(190);
    wait_idle();
    run_scenes(190);
    wait_idle();

    // smaller image, terminator at zero; sender now idles more than receiver
    send_idle_pct  = 69;
    recv_stall_pct = 23;
    write_register(REG_IMAGE_SIZE, $urandom_range(256, 2047));
    write_register(REG_TERMINATOR_ID, 0);
    run_scenes(370);
    wait_idle();

    // full image, random terminator, no idling at all
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_register(REG_IMAGE_SIZE, APB_DATA_W'(IMAGE_SIZE_RESET));
    write_register(REG_TERMINATOR_ID, $urandom_range(1, 254));
    run_scenes(380);
    wait_idle();

    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/vpd_pkg.sv
hdl/vpd_if.sv
hdl/vpd_ram.sv
hdl/vpd_packet_search.sv
sim/tb_vpd_packet_search.sv
